@@ sv/fpr_pkg.sv @@
// shared types, constants and coefficient table for the fan to parallel rebinning block
`default_nettype none

package fpr_pkg;

    // store geometry and query limits
    localparam int unsigned DETECTORS   = 256;
    localparam int unsigned VIEWS       = 512;
    localparam int unsigned ANGLES      = 360;
    localparam int unsigned DET_W       = $clog2(DETECTORS);
    localparam int unsigned VIEW_W      = $clog2(VIEWS);
    localparam int unsigned ADDR_W      = DET_W + VIEW_W;
    localparam logic [7:0]  PAR_CENTRE  = 8'd130;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    // configuration register indexes
    localparam logic [2:0] REG_DET_COUNT  = 3'd0;
    localparam logic [2:0] REG_VIEW_COUNT = 3'd1;
    localparam logic [2:0] REG_VIEW_STEP  = 3'd2;
    localparam logic [2:0] REG_FAN_STEP   = 3'd3;
    localparam logic [2:0] REG_INV_FAN    = 3'd4;
    localparam logic [2:0] REG_SOURCE     = 3'd5;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_HMUL,
        ST_HADD,
        ST_SQRT,
        ST_SMUL,
        ST_ASN,
        ST_TMUL,
        ST_TCHK,
        ST_VMUL1,
        ST_VMUL2,
        ST_VCHK,
        ST_RDB,
        ST_RDW,
        ST_RINT,
        ST_FMUL,
        ST_FIN,
        ST_DONE
    } fpr_state_t;

    // arcsine polynomial coefficients, Q4.30
    function automatic logic signed [33:0] asin_coef(input logic [2:0] idx);
        logic signed [33:0] c;
        begin
            case (idx)
                3'd0:    c = 34'sd1686629690;
                3'd1:    c = -34'sd230423709;
                3'd2:    c = 34'sd95540460;
                3'd3:    c = -34'sd53874250;
                3'd4:    c = 34'sd33169904;
                3'd5:    c = -34'sd18348236;
                3'd6:    c = 34'sd7161955;
                default: c = -34'sd1355590;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/fpr_if.sv @@
// item channels of the rebinning block: query/load input and result output
`default_nettype none

interface fpr_in_if;
    import fpr_pkg::*;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [7:0]          det_index;
    logic [8:0]          view_index;
    logic signed [31:0]  sample_value;
    logic [7:0]          out_bin;
    logic [8:0]          out_angle;

    modport source (output valid, cmd, det_index, view_index, sample_value, out_bin,
                    out_angle, input ready);
    modport sink   (input valid, cmd, det_index, view_index, sample_value, out_bin,
                    out_angle, output ready);
endinterface

interface fpr_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value;
    logic                in_range;

    modport source (output valid, value, in_range, input ready);
    modport sink   (input valid, value, in_range, output ready);
endinterface

`default_nettype wire

@@ sv/fan_to_parallel_rebinning.sv @@
// top level: sinogram store, apb registers and the iterative rebinning sequencer
//
// usage
//   req channel carries one item per handshake. a load item (cmd 0) writes
//   sample_value into the store at (det_index, view_index) in the cycle it is
//   accepted and produces no result; ready stays high so loads stream at one
//   item per cycle while no query is in flight. a query item (cmd 1) yields
//   exactly one result on rsp. a query runs through one sequencer: a 24-step
//   restoring divider, seven horner steps on the shared multiplier, a 31-step
//   bit serial square root, then nine more shared multiplies and four store
//   reads. a failed range check ends it early, and a fan row outside the
//   views skips its store reads. rsp is driven from an output register:
//   while a result waits for rsp.ready the block still takes loads and may
//   start the next query, which then holds in its last state until the
//   register frees. reset (rst_n low, asynchronous) returns the sequencer to
//   idle, clears the output valid and restores the register defaults; the
//   store is not cleared and entries read before being written hold anything.
//   configuration must be written over apb only while no query is in flight;
//   the block itself does not enforce this.
`default_nettype none

module fan_to_parallel_rebinning
    import fpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fpr_in_if.sink           req,
    fpr_out_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // configuration registers
    logic [8:0]  det_count_reg;
    logic [9:0]  view_count_reg;
    logic [23:0] view_step_reg;
    logic [23:0] fan_step_reg;
    logic [31:0] inv_fan_reg;
    logic [15:0] source_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_count_reg  <= 9'd256;
            view_count_reg <= 10'd360;
            view_step_reg  <= 24'd65536;
            fan_step_reg   <= 24'd65536;
            inv_fan_reg    <= 32'd3754936;
            source_reg     <= 16'd500;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_DET_COUNT:  det_count_reg  <= pwdata[8:0];
                REG_VIEW_COUNT: view_count_reg <= pwdata[9:0];
                REG_VIEW_STEP:  view_step_reg  <= pwdata[23:0];
                REG_FAN_STEP:   fan_step_reg   <= pwdata[23:0];
                REG_INV_FAN:    inv_fan_reg    <= pwdata;
                REG_SOURCE:     source_reg     <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[4:2])
            REG_DET_COUNT:  prdata = {23'd0, det_count_reg};
            REG_VIEW_COUNT: prdata = {22'd0, view_count_reg};
            REG_VIEW_STEP:  prdata = {8'd0, view_step_reg};
            REG_FAN_STEP:   prdata = {8'd0, fan_step_reg};
            REG_INV_FAN:    prdata = inv_fan_reg;
            REG_SOURCE:     prdata = {16'd0, source_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // counts saturated to the store size
    logic [8:0] nd_sat;
    logic [9:0] nv_sat;
    logic [7:0] half;

    assign nd_sat = (det_count_reg > 9'(DETECTORS)) ? 9'(DETECTORS) : det_count_reg;
    assign nv_sat = (view_count_reg > 10'(VIEWS)) ? 10'(VIEWS) : view_count_reg;
    assign half   = nd_sat[8:1];

    // sequencer and datapath registers
    fpr_state_t          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  out_value_reg, out_value_next;
    logic                out_range_reg, out_range_next;

    logic                neg_reg, neg_next;
    logic [7:0]          ax_reg, ax_next;
    logic [8:0]          angle_reg, angle_next;
    logic [15:0]         rem_reg, rem_next;
    logic [23:0]         dvd_reg, dvd_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic signed [33:0]  p_reg, p_next;
    logic [2:0]          idx_reg, idx_next;
    logic [61:0]         sv_reg, sv_next;
    logic [61:0]         sres_reg, sres_next;
    logic [60:0]         sbit_reg, sbit_next;
    logic signed [33:0]  asn_reg, asn_next;
    logic [7:0]          row_reg, row_next;
    logic                rsel_reg, rsel_next;
    logic [15:0]         uu_reg, uu_next;
    logic [15:0]         u_reg, u_next;
    logic signed [35:0]  ta_reg, ta_next;
    logic [VIEW_W-1:0]   n_reg, n_next;
    logic signed [31:0]  a_reg, a_next;
    logic signed [31:0]  p0_reg, p0_next;
    logic signed [31:0]  p1_reg, p1_next;
    logic                ok_reg, ok_next;
    logic signed [31:0]  res_value_reg, res_value_next;
    logic                res_range_reg, res_range_next;

    // shared multiplier, registered product
    logic signed [34:0]  mul_a, mul_b;
    logic signed [69:0]  prod_reg;

    // store
    logic [31:0]         store_mem [DETECTORS*VIEWS];
    logic [31:0]         rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                load_take;

    assign req.ready = (state_reg == ST_IDLE);
    assign load_take = req.valid && req.ready && (req.cmd == CMD_LOAD);

    // store write on a load item, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            store_mem[{req.det_index, req.view_index}] <= req.sample_value;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // intermediate values
    logic [16:0]         rem_shift;
    logic                div_ge;
    logic [61:0]         sq_try;
    logic signed [39:0]  tt;
    logic signed [23:0]  m_pos;
    logic signed [35:0]  t_pos;
    logic signed [19:0]  n_pos;
    logic signed [9:0]   row_off;
    logic signed [32:0]  diff_ab;
    logic signed [32:0]  diff_p;
    logic signed [33:0]  asn_val;
    logic                check_bad;
    logic                tchk_bad;
    logic                vchk_bad;
    logic                out_free;

    assign rem_shift = {rem_reg, dvd_reg[23]};
    assign div_ge    = (rem_shift >= {1'b0, source_reg});
    assign sq_try    = sres_reg + {1'b0, sbit_reg};
    assign tt        = prod_reg[69:30] + $signed({16'd0, half, 16'd0});
    assign m_pos     = tt[39:16];
    assign t_pos     = ta_reg - prod_reg[35:0];
    assign n_pos     = t_pos[35:16];
    assign row_off   = $signed({2'b00, row_reg}) - $signed({2'b00, half});
    assign diff_ab   = $signed({rd_data_reg[31], rd_data_reg}) - $signed({a_reg[31], a_reg});
    assign diff_p    = $signed({p1_reg[31], p1_reg}) - $signed({p0_reg[31], p0_reg});
    assign asn_val   = HALF_PI_Q30 - prod_reg[63:30];
    assign check_bad = (angle_reg >= 9'(ANGLES)) || (source_reg == 16'd0)
                       || ({8'd0, ax_reg} > source_reg);
    assign tchk_bad  = m_pos[23] || (m_pos >= $signed({15'd0, nd_sat}) - 24'sd1);
    assign vchk_bad  = n_pos[19] || (n_pos >= $signed({10'd0, nv_sat}) - 20'sd1);
    assign out_free  = !out_valid_reg || rsp.ready;

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HMUL:
            begin
                mul_a = 35'(p_reg);
                mul_b = $signed({18'd0, dvd_reg[16:0]});
            end
            ST_SMUL:
            begin
                mul_a = $signed({4'd0, sres_reg[30:0]});
                mul_b = 35'(p_reg);
            end
            ST_TMUL:
            begin
                mul_a = 35'(asn_reg);
                mul_b = $signed({3'd0, inv_fan_reg});
            end
            ST_VMUL1:
            begin
                mul_a = $signed({26'd0, angle_reg});
                mul_b = $signed({11'd0, view_step_reg});
            end
            ST_VMUL2:
            begin
                mul_a = 35'(row_off);
                mul_b = $signed({11'd0, fan_step_reg});
            end
            ST_RDW:
            begin
                mul_a = $signed({19'd0, u_reg});
                mul_b = 35'(diff_ab);
            end
            ST_FMUL:
            begin
                mul_a = $signed({19'd0, uu_reg});
                mul_b = 35'(diff_p);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // store read address
    always_comb
    begin
        case (state_reg)
            ST_VCHK: rd_addr = {row_reg, n_pos[VIEW_W-1:0]};
            default: rd_addr = {row_reg, n_reg + VIEW_W'(1)};
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.cmd == CMD_QUERY)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = check_bad ? ST_DONE : ST_DIV;
            ST_DIV:   state_next = (cnt_reg == 5'd23) ? ST_HMUL : ST_DIV;
            ST_HMUL:  state_next = ST_HADD;
            ST_HADD:  state_next = (idx_reg == 3'd0) ? ST_SQRT : ST_HMUL;
            ST_SQRT:  state_next = sbit_reg[0] ? ST_SMUL : ST_SQRT;
            ST_SMUL:  state_next = ST_ASN;
            ST_ASN:   state_next = ST_TMUL;
            ST_TMUL:  state_next = ST_TCHK;
            ST_TCHK:  state_next = tchk_bad ? ST_DONE : ST_VMUL1;
            ST_VMUL1: state_next = ST_VMUL2;
            ST_VMUL2: state_next = ST_VCHK;
            ST_VCHK:
            begin
                if (!vchk_bad)
                begin
                    state_next = ST_RDB;
                end
                else
                begin
                    state_next = rsel_reg ? ST_FMUL : ST_VMUL1;
                end
            end
            ST_RDB:   state_next = ST_RDW;
            ST_RDW:   state_next = ST_RINT;
            ST_RINT:  state_next = rsel_reg ? ST_FMUL : ST_VMUL1;
            ST_FMUL:  state_next = ST_FIN;
            ST_FIN:   state_next = ST_DONE;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        neg_next       = neg_reg;
        ax_next        = ax_reg;
        angle_next     = angle_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        sv_next        = sv_reg;
        sres_next      = sres_reg;
        sbit_next      = sbit_reg;
        asn_next       = asn_reg;
        row_next       = row_reg;
        rsel_next      = rsel_reg;
        uu_next        = uu_reg;
        u_next         = u_reg;
        ta_next        = ta_reg;
        n_next         = n_reg;
        a_next         = a_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        ok_next        = ok_reg;
        res_value_next = res_value_reg;
        res_range_next = res_range_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                angle_next     = req.out_angle;
                neg_next       = (req.out_bin < PAR_CENTRE);
                ax_next        = (req.out_bin < PAR_CENTRE) ? PAR_CENTRE - req.out_bin
                                                             : req.out_bin - PAR_CENTRE;
                ok_next        = 1'b1;
                res_value_next = '0;
                res_range_next = 1'b0;
            end
            ST_CHECK:
            begin
                rem_next = '0;
                dvd_next = {ax_reg, 16'd0};
                cnt_next = '0;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = div_ge ? 16'(rem_shift - {1'b0, source_reg}) : rem_shift[15:0];
                dvd_next = {dvd_reg[22:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                p_next   = asin_coef(3'd7);
                idx_next = 3'd6;
            end
            ST_HMUL: ;
            ST_HADD:
            begin
                p_next    = prod_reg[49:16] + asin_coef(idx_reg);
                idx_next  = idx_reg - 3'd1;
                sv_next   = {1'b0, 17'(17'h10000 - dvd_reg[16:0]), 44'd0};
                sres_next = '0;
                sbit_next = {1'b1, 60'd0};
            end
            ST_SQRT:
            begin
                // bit serial square root, two radicand bits per cycle
                if (sv_reg >= sq_try)
                begin
                    sv_next   = sv_reg - sq_try;
                    sres_next = (sres_reg >> 1) + {1'b0, sbit_reg};
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            ST_SMUL: ;
            ST_ASN:   asn_next = neg_reg ? -asn_val : asn_val;
            ST_TMUL: ;
            ST_TCHK:
            begin
                row_next  = m_pos[7:0];
                uu_next   = tt[15:0];
                rsel_next = 1'b0;
            end
            ST_VMUL1: ;
            ST_VMUL2: ta_next = $signed({3'd0, prod_reg[32:0]});
            ST_VCHK:
            begin
                n_next = n_pos[VIEW_W-1:0];
                u_next = t_pos[15:0];
                if (vchk_bad)
                begin
                    ok_next = 1'b0;
                    if (rsel_reg)
                    begin
                        p1_next = '0;
                    end
                    else
                    begin
                        p0_next   = '0;
                        rsel_next = 1'b1;
                        row_next  = row_reg + 8'd1;
                    end
                end
            end
            ST_RDB:   a_next = rd_data_reg;
            ST_RDW: ;
            ST_RINT:
            begin
                if (rsel_reg)
                begin
                    p1_next = a_reg + prod_reg[47:16];
                end
                else
                begin
                    p0_next   = a_reg + prod_reg[47:16];
                    rsel_next = 1'b1;
                    row_next  = row_reg + 8'd1;
                end
            end
            ST_FMUL: ;
            ST_FIN:
            begin
                res_value_next = p0_reg + prod_reg[47:16];
                res_range_next = ok_reg;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_range_next = out_range_reg;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_value_reg;
            out_range_next = res_range_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.value    = out_value_reg;
    assign rsp.in_range = out_range_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= mul_a * mul_b;
        out_value_reg <= out_value_next;
        out_range_reg <= out_range_next;
        neg_reg       <= neg_next;
        ax_reg        <= ax_next;
        angle_reg     <= angle_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        cnt_reg       <= cnt_next;
        p_reg         <= p_next;
        idx_reg       <= idx_next;
        sv_reg        <= sv_next;
        sres_reg      <= sres_next;
        sbit_reg      <= sbit_next;
        asn_reg       <= asn_next;
        row_reg       <= row_next;
        rsel_reg      <= rsel_next;
        uu_reg        <= uu_next;
        u_reg         <= u_next;
        ta_reg        <= ta_next;
        n_reg         <= n_next;
        a_reg         <= a_next;
        p0_reg        <= p0_next;
        p1_reg        <= p1_next;
        ok_reg        <= ok_next;
        res_value_reg <= res_value_next;
        res_range_reg <= res_range_next;
    end

endmodule

`default_nettype wire

@@ sv/fpr_checker.sv @@
// port level checks for the rebinning block and their binding
`default_nettype none

module fpr_checker
    import fpr_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic req_cmd,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic pready
);

    // no result shows while in reset
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // a query occupies the sequencer for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_cmd == CMD_QUERY) |=> !req_ready)
        else $error("ready after query acceptance");

    // a load leaves the block ready for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_cmd == CMD_LOAD) |=> req_ready)
        else $error("load item stalled the input");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result dropped while stalled");

    // apb never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind fan_to_parallel_rebinning fpr_checker u_fpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pready    (pready)
);

`default_nettype wire
